FILE: sv/mcf_pkg.sv
`timescale 1ns / 1ps

package mcf_pkg;

  // node, arc and value widths
  localparam int NODE_W     = 9;
  localparam int NUM_NODES  = 512;
  localparam int ARC_W      = 13;
  localparam int ARC_SLOTS  = 8192;
  localparam int PTR_W      = 14;   // arc index plus the empty-list flag
  localparam int CAP_W      = 16;
  localparam int COST_W     = 16;
  localparam int IN_COST_W  = 15;
  localparam int DIST_W     = 32;
  localparam int DT_W       = 27;   // a finite sink distance stays below the infinity mark
  localparam int PROD_W     = DT_W + CAP_W;
  localparam int TOTAL_W    = 47;
  localparam int QCNT_W     = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [PTR_W-1:0]  ARC_NONE = {1'b1, {ARC_W{1'b0}}};
  localparam logic [DIST_W-1:0] DIST_INF = 32'h07ff_ffff;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SINK   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEMAND = 2'd2;

  typedef struct packed {
    logic [NODE_W-1:0] source;
    logic [NODE_W-1:0] sink;
    logic [CAP_W-1:0]  demand;
  } cfg_t;

  typedef struct packed {
    logic [NODE_W-1:0] head;
    logic [COST_W-1:0] cost;
    logic [PTR_W-1:0]  next;
  } arc_t;

  typedef struct packed {
    logic              inq;
    logic [DIST_W-1:0] dval;
  } dist_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [ARC_W-1:0]  arc;
  } pred_t;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_L1, ST_L2, ST_L3, ST_CHK, ST_INIT, ST_SEED,
    ST_POP, ST_POP1, ST_POP2, ST_POP3, ST_ARC0, ST_ARC1, ST_ARC2,
    ST_T0, ST_T1, ST_W0, ST_W1, ST_W2, ST_MUL, ST_ACC,
    ST_A0, ST_A1, ST_A2, ST_A3, ST_DONE
  } state_t;

endpackage

FILE: sv/min_cost_flow_spfa_top.sv
`timescale 1ns / 1ps

// Min-cost flow by successive shortest paths with a queue-driven Bellman-Ford.
// Input: one arc per transfer (start high while busy low) carrying tail, head,
//   capacity and unit cost; each arc is stored with a zero-capacity reverse arc.
//   Arcs beyond the 8192-entry arc store are dropped.
// Configuration: cfg_we with cfg_index 0 = source, 1 = sink, 2 = flow demand;
//   the user writes these only while the block is idle; the block itself does not enforce this.
// Loading an arc: accept in idle, then read-modify-write in states L1, L2 and L3
//   on the list-head memory, which has one read port (read head of list, link
//   forward arc, then the same for the reverse arc).
// After the arc marked last the solve runs; its length depends on the graph:
//   per augmenting path a distance reset of all 512 nodes, a queue-driven scan
//   that pops nodes and scans their arcs, then a bottleneck walk and a capacity
//   update along the path nodes.
// One result transfer follows (out_valid for one cycle: total cost, or the
//   infeasible flag with cost zero); the receiver cannot stall.
// After each result and after reset a pass over all 512 adjacency list heads
//   clears them, busy high throughout. Reset restores source 0, sink 511, demand 1.
module min_cost_flow_spfa_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [mcf_pkg::NODE_W-1:0]          in_tail_node,
  input  logic [mcf_pkg::NODE_W-1:0]          in_head_node,
  input  logic [mcf_pkg::CAP_W-1:0]           in_capacity,
  input  logic [mcf_pkg::IN_COST_W-1:0]       in_unit_cost,
  input  logic                                in_last_edge,
  input  logic                                cfg_we,
  input  logic [mcf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mcf_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output logic                                out_valid,
  output logic [mcf_pkg::TOTAL_W-1:0]         out_total_cost,
  output logic                                out_infeasible
);

  mcf_pkg::cfg_t cfg_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source <= '0;
      cfg_r.sink   <= mcf_pkg::NODE_W'(mcf_pkg::NUM_NODES - 1);
      cfg_r.demand <= mcf_pkg::CAP_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        mcf_pkg::CFG_SOURCE: cfg_r.source <= cfg_wdata[mcf_pkg::NODE_W-1:0];
        mcf_pkg::CFG_SINK:   cfg_r.sink   <= cfg_wdata[mcf_pkg::NODE_W-1:0];
        mcf_pkg::CFG_DEMAND: cfg_r.demand <= cfg_wdata[mcf_pkg::CAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mcf_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .start      (start),
    .busy       (busy),
    .tail_node  (in_tail_node),
    .head_node  (in_head_node),
    .capacity   (in_capacity),
    .unit_cost  (in_unit_cost),
    .last_edge  (in_last_edge),
    .out_valid  (out_valid),
    .total_cost (out_total_cost),
    .infeasible (out_infeasible)
  );

endmodule

FILE: sv/mcf_ram.sv
`timescale 1ns / 1ps

// simple dual-port RAM, registered read
module mcf_ram #(
  parameter int AW = 9,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/mcf_engine.sv
`timescale 1ns / 1ps

module mcf_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  mcf_pkg::cfg_t                     cfg,
  input  logic                              start,
  output logic                              busy,
  input  logic [mcf_pkg::NODE_W-1:0]        tail_node,
  input  logic [mcf_pkg::NODE_W-1:0]        head_node,
  input  logic [mcf_pkg::CAP_W-1:0]         capacity,
  input  logic [mcf_pkg::IN_COST_W-1:0]     unit_cost,
  input  logic                              last_edge,
  output logic                              out_valid,
  output logic [mcf_pkg::TOTAL_W-1:0]       total_cost,
  output logic                              infeasible
);

  localparam int NW = mcf_pkg::NODE_W;
  localparam int AW = mcf_pkg::ARC_W;
  localparam int PW = mcf_pkg::PTR_W;
  localparam int CW = mcf_pkg::CAP_W;
  localparam int DW = mcf_pkg::DIST_W;
  localparam int QW = mcf_pkg::QCNT_W;
  localparam int COST_W = mcf_pkg::COST_W;

  mcf_pkg::state_t state_r, state_nxt;

  // control and datapath registers
  logic [NW-1:0]                  idx_r;
  logic [PW-1:0]                  arc_cnt_r;
  logic [NW-1:0]                  tail_r, head_r;
  logic [CW-1:0]                  cap_in_r;
  logic [mcf_pkg::IN_COST_W-1:0]  cost_r;
  logic                           last_r;
  logic [CW-1:0]                  left_r;
  logic [mcf_pkg::TOTAL_W-1:0]    total_r;
  logic                           res_inf_r;
  logic [NW-1:0]                  qh_r;
  logic [QW-1:0]                  qn_r;
  logic [NW-1:0]                  v_r;
  logic [DW-1:0]                  dv_r;
  logic [PW-1:0]                  a_r;
  logic [NW-1:0]                  h_r;
  logic [DW-1:0]                  nd_r;
  logic [CW-1:0]                  arccap_r;
  logic [PW-1:0]                  next_r;
  logic [mcf_pkg::DT_W-1:0]       dt_r;
  logic [CW-1:0]                  d_r;
  logic [QW-1:0]                  steps_r;
  logic [NW-1:0]                  pn_r;
  logic [AW-1:0]                  pa_r;
  logic [mcf_pkg::PROD_W-1:0]     prod_r;

  // memory ports
  logic           first_we;
  logic [NW-1:0]  first_waddr, first_raddr;
  logic [PW-1:0]  first_wdata, first_rd;
  logic           arc_we;
  logic [AW-1:0]  arc_waddr, arc_raddr;
  mcf_pkg::arc_t  arc_wdata, arc_rd;
  logic           cap_we;
  logic [AW-1:0]  cap_waddr, cap_raddr;
  logic [CW-1:0]  cap_wdata, cap_rd;
  logic           dist_we;
  logic [NW-1:0]  dist_waddr, dist_raddr;
  mcf_pkg::dist_t dist_wdata, dist_rd;
  logic           q_we;
  logic [NW-1:0]  q_waddr, q_raddr, q_wdata, q_rd;
  logic           pred_we;
  logic [NW-1:0]  pred_waddr, pred_raddr;
  mcf_pkg::pred_t pred_wdata, pred_rd;

  logic           arc_ok;
  logic           relax;
  logic           enq;
  logic [AW-1:0]  a_idx;

  assign a_idx  = arc_cnt_r[AW-1:0];
  assign arc_ok = arc_cnt_r <= PW'(mcf_pkg::ARC_SLOTS - 2);
  assign relax  = (arccap_r != '0) && ($signed(dist_rd.dval) > $signed(nd_r));
  assign enq    = relax && !dist_rd.inq && !qn_r[QW-1];

  mcf_ram #(.AW(NW), .DW(PW)) u_first (
    .clk(clk), .we(first_we), .waddr(first_waddr), .wdata(first_wdata),
    .raddr(first_raddr), .rdata(first_rd)
  );
  mcf_ram #(.AW(AW), .DW($bits(mcf_pkg::arc_t))) u_arc (
    .clk(clk), .we(arc_we), .waddr(arc_waddr), .wdata(arc_wdata),
    .raddr(arc_raddr), .rdata(arc_rd)
  );
  mcf_ram #(.AW(AW), .DW(CW)) u_cap (
    .clk(clk), .we(cap_we), .waddr(cap_waddr), .wdata(cap_wdata),
    .raddr(cap_raddr), .rdata(cap_rd)
  );
  mcf_ram #(.AW(NW), .DW($bits(mcf_pkg::dist_t))) u_dist (
    .clk(clk), .we(dist_we), .waddr(dist_waddr), .wdata(dist_wdata),
    .raddr(dist_raddr), .rdata(dist_rd)
  );
  mcf_ram #(.AW(NW), .DW(NW)) u_queue (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rd)
  );
  mcf_ram #(.AW(NW), .DW($bits(mcf_pkg::pred_t))) u_pred (
    .clk(clk), .we(pred_we), .waddr(pred_waddr), .wdata(pred_wdata),
    .raddr(pred_raddr), .rdata(pred_rd)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mcf_pkg::ST_CLR:  if (idx_r == NW'(mcf_pkg::NUM_NODES - 1)) state_nxt = mcf_pkg::ST_IDLE;
      mcf_pkg::ST_IDLE: if (start) state_nxt = mcf_pkg::ST_L1;
      mcf_pkg::ST_L1:   state_nxt = mcf_pkg::ST_L2;
      mcf_pkg::ST_L2:   state_nxt = mcf_pkg::ST_L3;
      mcf_pkg::ST_L3:   state_nxt = last_r ? mcf_pkg::ST_CHK : mcf_pkg::ST_IDLE;
      mcf_pkg::ST_CHK: begin
        if (left_r == '0 || cfg.source == cfg.sink) state_nxt = mcf_pkg::ST_DONE;
        else state_nxt = mcf_pkg::ST_INIT;
      end
      mcf_pkg::ST_INIT: if (idx_r == NW'(mcf_pkg::NUM_NODES - 1)) state_nxt = mcf_pkg::ST_SEED;
      mcf_pkg::ST_SEED: state_nxt = mcf_pkg::ST_POP;
      mcf_pkg::ST_POP:  state_nxt = (qn_r == '0) ? mcf_pkg::ST_T0 : mcf_pkg::ST_POP1;
      mcf_pkg::ST_POP1: state_nxt = mcf_pkg::ST_POP2;
      mcf_pkg::ST_POP2: state_nxt = mcf_pkg::ST_POP3;
      mcf_pkg::ST_POP3: state_nxt = first_rd[AW] ? mcf_pkg::ST_POP : mcf_pkg::ST_ARC0;
      mcf_pkg::ST_ARC0: state_nxt = mcf_pkg::ST_ARC1;
      mcf_pkg::ST_ARC1: state_nxt = mcf_pkg::ST_ARC2;
      mcf_pkg::ST_ARC2: state_nxt = next_r[AW] ? mcf_pkg::ST_POP : mcf_pkg::ST_ARC0;
      mcf_pkg::ST_T0:   state_nxt = mcf_pkg::ST_T1;
      mcf_pkg::ST_T1: begin
        if ($signed(dist_rd.dval) >= $signed(mcf_pkg::DIST_INF)) state_nxt = mcf_pkg::ST_DONE;
        else state_nxt = mcf_pkg::ST_W0;
      end
      mcf_pkg::ST_W0: begin
        if (v_r == cfg.source) state_nxt = mcf_pkg::ST_MUL;
        else if (steps_r == QW'(mcf_pkg::NUM_NODES)) state_nxt = mcf_pkg::ST_DONE;
        else state_nxt = mcf_pkg::ST_W1;
      end
      mcf_pkg::ST_W1:   state_nxt = mcf_pkg::ST_W2;
      mcf_pkg::ST_W2:   state_nxt = mcf_pkg::ST_W0;
      mcf_pkg::ST_MUL:  state_nxt = mcf_pkg::ST_ACC;
      mcf_pkg::ST_ACC:  state_nxt = mcf_pkg::ST_A0;
      mcf_pkg::ST_A0:   state_nxt = (v_r == cfg.source) ? mcf_pkg::ST_CHK : mcf_pkg::ST_A1;
      mcf_pkg::ST_A1:   state_nxt = mcf_pkg::ST_A2;
      mcf_pkg::ST_A2:   state_nxt = mcf_pkg::ST_A3;
      mcf_pkg::ST_A3:   state_nxt = mcf_pkg::ST_A0;
      mcf_pkg::ST_DONE: state_nxt = mcf_pkg::ST_CLR;
      default:          state_nxt = mcf_pkg::ST_CLR;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    busy        = (state_r != mcf_pkg::ST_IDLE);
    out_valid   = (state_r == mcf_pkg::ST_DONE);
    total_cost  = res_inf_r ? '0 : total_r;
    infeasible  = res_inf_r;

    first_we    = 1'b0;
    first_waddr = idx_r;
    first_wdata = mcf_pkg::ARC_NONE;
    first_raddr = v_r;
    arc_we      = 1'b0;
    arc_waddr   = a_idx;
    arc_wdata   = '{head: head_r, cost: COST_W'({1'b0, cost_r}), next: first_rd};
    arc_raddr   = a_r[AW-1:0];
    cap_we      = 1'b0;
    cap_waddr   = a_idx;
    cap_wdata   = cap_in_r;
    cap_raddr   = a_r[AW-1:0];
    dist_we     = 1'b0;
    dist_waddr  = idx_r;
    dist_wdata  = '{inq: 1'b0, dval: mcf_pkg::DIST_INF};
    dist_raddr  = v_r;
    q_we        = 1'b0;
    q_waddr     = '0;
    q_wdata     = cfg.source;
    q_raddr     = qh_r;
    pred_we     = 1'b0;
    pred_waddr  = h_r;
    pred_wdata  = '{node: v_r, arc: a_r[AW-1:0]};
    pred_raddr  = v_r;

    unique case (state_r)
      mcf_pkg::ST_CLR: first_we = 1'b1;
      mcf_pkg::ST_IDLE: first_raddr = tail_node;
      mcf_pkg::ST_L1: begin
        // forward arc at the head of the tail's list
        arc_we      = arc_ok;
        cap_we      = arc_ok;
        first_we    = arc_ok;
        first_waddr = tail_r;
        first_wdata = arc_cnt_r;
      end
      mcf_pkg::ST_L2: first_raddr = head_r;
      mcf_pkg::ST_L3: begin
        // reverse arc: no capacity, negated cost
        arc_we      = arc_ok;
        arc_waddr   = a_idx | AW'(1);
        arc_wdata   = '{head: tail_r, cost: COST_W'(0) - COST_W'({1'b0, cost_r}),
                        next: first_rd};
        cap_we      = arc_ok;
        cap_waddr   = a_idx | AW'(1);
        cap_wdata   = '0;
        first_we    = arc_ok;
        first_waddr = head_r;
        first_wdata = arc_cnt_r | PW'(1);
      end
      mcf_pkg::ST_INIT: dist_we = 1'b1;
      mcf_pkg::ST_SEED: begin
        dist_we    = 1'b1;
        dist_waddr = cfg.source;
        dist_wdata = '{inq: 1'b1, dval: '0};
        q_we       = 1'b1;
      end
      mcf_pkg::ST_POP1: dist_raddr = q_rd;
      mcf_pkg::ST_POP2: begin
        // dequeued node leaves the queue
        dist_we    = 1'b1;
        dist_waddr = v_r;
        dist_wdata = '{inq: 1'b0, dval: dist_rd.dval};
      end
      mcf_pkg::ST_ARC1: dist_raddr = arc_rd.head;
      mcf_pkg::ST_ARC2: begin
        dist_we    = relax;
        dist_waddr = h_r;
        dist_wdata = '{inq: dist_rd.inq | enq, dval: nd_r};
        pred_we    = relax;
        q_we       = enq;
        q_waddr    = qh_r + qn_r[NW-1:0];
        q_wdata    = h_r;
      end
      mcf_pkg::ST_T0: dist_raddr = cfg.sink;
      mcf_pkg::ST_W1: cap_raddr = pred_rd.arc;
      mcf_pkg::ST_A1: cap_raddr = pred_rd.arc;
      mcf_pkg::ST_A2: begin
        cap_we    = 1'b1;
        cap_waddr = pa_r;
        cap_wdata = cap_rd - d_r;
        cap_raddr = pa_r ^ AW'(1);
      end
      mcf_pkg::ST_A3: begin
        cap_we    = 1'b1;
        cap_waddr = pa_r ^ AW'(1);
        cap_wdata = cap_rd + d_r;
      end
      default: begin
      end
    endcase
  end

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mcf_pkg::ST_CLR;
      idx_r     <= '0;
      arc_cnt_r <= '0;
      res_inf_r <= 1'b0;
      qn_r      <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        mcf_pkg::ST_CLR:  idx_r <= idx_r + NW'(1);
        mcf_pkg::ST_IDLE: begin
          if (start) begin
            tail_r   <= tail_node;
            head_r   <= head_node;
            cap_in_r <= capacity;
            cost_r   <= unit_cost;
            last_r   <= last_edge;
          end
        end
        mcf_pkg::ST_L3: begin
          if (arc_ok) arc_cnt_r <= arc_cnt_r + PW'(2);
          left_r    <= cfg.demand;
          total_r   <= '0;
          res_inf_r <= 1'b0;
        end
        mcf_pkg::ST_CHK:  idx_r <= '0;
        mcf_pkg::ST_INIT: idx_r <= idx_r + NW'(1);
        mcf_pkg::ST_SEED: begin
          qh_r <= '0;
          qn_r <= QW'(1);
        end
        mcf_pkg::ST_POP1: begin
          v_r  <= q_rd;
          qh_r <= qh_r + NW'(1);
          qn_r <= qn_r - QW'(1);
        end
        mcf_pkg::ST_POP2: dv_r <= dist_rd.dval;
        mcf_pkg::ST_POP3: a_r  <= first_rd;
        mcf_pkg::ST_ARC1: begin
          h_r      <= arc_rd.head;
          nd_r     <= dv_r + DW'($signed(arc_rd.cost));
          next_r   <= arc_rd.next;
          arccap_r <= cap_rd;
        end
        mcf_pkg::ST_ARC2: begin
          if (enq) qn_r <= qn_r + QW'(1);
          if (relax && h_r == v_r) dv_r <= nd_r;
          a_r <= next_r;
        end
        mcf_pkg::ST_T1: begin
          if ($signed(dist_rd.dval) >= $signed(mcf_pkg::DIST_INF)) res_inf_r <= 1'b1;
          dt_r    <= dist_rd.dval[mcf_pkg::DT_W-1:0];
          d_r     <= left_r;
          steps_r <= '0;
          v_r     <= cfg.sink;
        end
        mcf_pkg::ST_W0: begin
          if (v_r != cfg.source && steps_r == QW'(mcf_pkg::NUM_NODES)) res_inf_r <= 1'b1;
          steps_r <= steps_r + QW'(1);
        end
        mcf_pkg::ST_W1: begin
          pn_r <= pred_rd.node;
          pa_r <= pred_rd.arc;
        end
        mcf_pkg::ST_W2: begin
          if (cap_rd < d_r) d_r <= cap_rd;
          v_r <= pn_r;
        end
        mcf_pkg::ST_MUL: begin
          prod_r <= dt_r * d_r;
          v_r    <= cfg.sink;
        end
        mcf_pkg::ST_ACC: begin
          total_r <= total_r + mcf_pkg::TOTAL_W'(prod_r);
          left_r  <= left_r - d_r;
        end
        mcf_pkg::ST_A1: begin
          pn_r <= pred_rd.node;
          pa_r <= pred_rd.arc;
        end
        mcf_pkg::ST_A3: v_r <= pn_r;
        mcf_pkg::ST_DONE: begin
          idx_r     <= '0;
          arc_cnt_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: verif/tb_min_cost_flow_spfa_top.sv
`timescale 1ns / 1ps

module tb_min_cost_flow_spfa_top;

  localparam int NODE_W     = mcf_pkg::NODE_W;
  localparam int NUM_NODES  = mcf_pkg::NUM_NODES;
  localparam int ARC_SLOTS  = mcf_pkg::ARC_SLOTS;
  localparam int CAP_W      = mcf_pkg::CAP_W;
  localparam int IN_COST_W  = mcf_pkg::IN_COST_W;
  localparam int TOTAL_W    = mcf_pkg::TOTAL_W;
  localparam int CFG_IDX_W  = mcf_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = mcf_pkg::CFG_DATA_W;
  localparam longint DIST_INF = longint'(mcf_pkg::DIST_INF);
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE = mcf_pkg::CFG_SOURCE;
  localparam logic [CFG_IDX_W-1:0] CFG_SINK   = mcf_pkg::CFG_SINK;
  localparam logic [CFG_IDX_W-1:0] CFG_DEMAND = mcf_pkg::CFG_DEMAND;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;  // no register behind it

  localparam int IDLE_LIMIT = 200000;
  localparam int RAND_ARCS  = 1050;
  localparam int NO_ARC     = -1;

  // flow predictor and expected-result store
  class flow_scoreboard;
    typedef struct {
      bit [TOTAL_W-1:0] cost;
      bit               infeasible;
    } flow_res_t;

    bit [NODE_W-1:0] src_node, snk_node;
    bit [CAP_W-1:0]  demand;
    int         arc_to[ARC_SLOTS];
    int         arc_cap[ARC_SLOTS];
    int         arc_price[ARC_SLOTS];
    int         arc_pair[ARC_SLOTS];
    int         arc_link[ARC_SLOTS];
    int         list_head[NUM_NODES];
    int         n_arcs;
    longint     node_dist[NUM_NODES];
    bit         queued[NUM_NODES];
    int         fifo[NUM_NODES];
    int         prev_node[NUM_NODES];
    int         prev_arc[NUM_NODES];
    flow_res_t  expected_q[$];
    int         mismatches;
    int         results_seen;

    function new();
      src_node = '0;
      snk_node = NODE_W'(NUM_NODES - 1);
      demand = CAP_W'(1);
      clear_lists();
    endfunction

    function void clear_lists();
      foreach (list_head[i]) list_head[i] = NO_ARC;
      n_arcs = 0;
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_SOURCE: src_node = val[NODE_W-1:0];
        CFG_SINK:   snk_node = val[NODE_W-1:0];
        CFG_DEMAND: demand   = val;
        default: ;
      endcase
    endfunction

    function void link(int a, int from, int to, int cap, int price, int pair);
      arc_to[a] = to;
      arc_cap[a] = cap;
      arc_price[a] = price;
      arc_pair[a] = pair;
      arc_link[a] = list_head[from];
      list_head[from] = a;
    endfunction

    // queue-driven Bellman-Ford from s over the residual arcs
    function void cheapest_paths(int s);
      int qh, qn, v, a, h;
      longint nd;
      qh = 0;
      foreach (node_dist[i]) begin
        node_dist[i] = DIST_INF;
        queued[i] = 0;
      end
      node_dist[s] = 0;
      fifo[0] = s;
      qn = 1;
      queued[s] = 1;
      while (qn > 0) begin
        v = fifo[qh];
        qh = (qh + 1) % NUM_NODES;
        qn--;
        queued[v] = 0;
        for (a = list_head[v]; a != NO_ARC; a = arc_link[a]) begin
          h = arc_to[a];
          nd = node_dist[v] + arc_price[a];
          if (arc_cap[a] > 0 && node_dist[h] > nd) begin
            node_dist[h] = nd;
            prev_node[h] = v;
            prev_arc[h] = a;
            if (!queued[h] && qn < NUM_NODES) begin
              queued[h] = 1;
              fifo[(qh + qn) % NUM_NODES] = h;
              qn++;
            end
          end
        end
      end
    endfunction

    // successive shortest paths; returns 1 when the demand is routed or source equals sink
    function bit route_flow(output longint total);
      int s, t, left, d, steps, v, a;
      s = src_node;
      t = snk_node;
      left = demand;
      total = 0;
      while (left > 0) begin
        if (s == t) break;
        cheapest_paths(s);
        if (node_dist[t] >= DIST_INF) return 0;
        d = left;
        steps = 0;
        for (v = t; v != s; v = prev_node[v]) begin
          steps++;
          if (steps > NUM_NODES) return 0;
          if (arc_cap[prev_arc[v]] < d) d = arc_cap[prev_arc[v]];
        end
        left -= d;
        total += node_dist[t] * d;
        for (v = t; v != s; v = prev_node[v]) begin
          a = prev_arc[v];
          arc_cap[a] -= d;
          arc_cap[arc_pair[a]] += d;
        end
      end
      return 1;
    endfunction

    function void note_arc(int tail, int head, int cap, int price, bit last);
      flow_res_t r;
      longint total;
      if (n_arcs + 2 <= ARC_SLOTS) begin
        link(n_arcs, tail, head, cap, price, n_arcs + 1);
        link(n_arcs + 1, head, tail, 0, -price, n_arcs);
        n_arcs += 2;
      end
      if (last) begin
        if (route_flow(total)) begin
          r.cost = total[TOTAL_W-1:0];
          r.infeasible = 0;
        end else begin
          r.cost = '0;
          r.infeasible = 1;
        end
        expected_q.insert(expected_q.size(), r);
        clear_lists();
      end
    endfunction

    function void check(bit [TOTAL_W-1:0] cost, bit infeasible);
      flow_res_t r;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result cost=%0d infeasible=%0b", cost, infeasible);
        return;
      end
      r = expected_q.pop_front();
      if (r.cost !== cost || r.infeasible !== infeasible) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d: expected cost=%0d infeasible=%0b, %s%0d %s%0b",
                   results_seen, r.cost, r.infeasible, "got cost=", cost,
                   "infeasible=", infeasible);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  typedef struct {
    bit [NODE_W-1:0]    tail;
    bit [NODE_W-1:0]    head;
    bit [CAP_W-1:0]     cap;
    bit [IN_COST_W-1:0] price;
  } arc_item_t;

  logic                  clk, rst_n, start, busy;
  logic [NODE_W-1:0]     in_tail_node, in_head_node;
  logic [CAP_W-1:0]      in_capacity;
  logic [IN_COST_W-1:0]  in_unit_cost;
  logic                  in_last_edge;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  out_valid;
  logic [TOTAL_W-1:0]    out_total_cost;
  logic                  out_infeasible;

  flow_scoreboard sb = new();
  int idle_cycles;
  int arcs_sent;
  int graphs_sent;

  min_cost_flow_spfa_top u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_tail_node(in_tail_node), .in_head_node(in_head_node),
    .in_capacity(in_capacity), .in_unit_cost(in_unit_cost),
    .in_last_edge(in_last_edge),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_total_cost(out_total_cost),
    .out_infeasible(out_infeasible)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // result transfers
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check(out_total_cost, out_infeasible);
  end

  // watchdog: cycles without any transfer
  always @(posedge clk) begin
    if ((rst_n && start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", idle_cycles);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // wait for all results and the clearing pass
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_regs(bit [CFG_IDX_W-1:0] idx_q[$], bit [CFG_DATA_W-1:0] val_q[$]);
    foreach (idx_q[i]) begin
      cfg_we <= 1;
      cfg_index <= idx_q[i];
      cfg_wdata <= val_q[i];
      @(posedge clk);
      sb.write_reg(idx_q[i], val_q[i]);
    end
    cfg_we <= 0;
  endtask

  task automatic set_flow(int s, int t, int d);
    wait_idle();
    write_regs('{CFG_SOURCE, CFG_SINK, CFG_DEMAND},
               '{CFG_DATA_W'(s), CFG_DATA_W'(t), CFG_DATA_W'(d)});
  endtask

  // one graph: arcs in order, the final one marked last
  task automatic send_graph(arc_item_t arcs[$], int idle_pct);
    bit last;
    foreach (arcs[i]) begin
      last = (i == arcs.size() - 1);
      // sender stays idle at random, as set by idle_pct
      while ($urandom_range(99) < idle_pct) begin
        start <= 0;
        @(posedge clk);
      end
      in_tail_node <= arcs[i].tail;
      in_head_node <= arcs[i].head;
      in_capacity  <= arcs[i].cap;
      in_unit_cost <= arcs[i].price;
      in_last_edge <= last;
      start <= 1;
      @(posedge clk);
      while (busy) @(posedge clk);
      sb.note_arc(arcs[i].tail, arcs[i].head, arcs[i].cap, arcs[i].price, last);
      arcs_sent++;
      if (last) start <= 0;
    end
    graphs_sent++;
  endtask

  function automatic arc_item_t mk(int t, int h, int c, int u);
    arc_item_t a;
    a.tail = NODE_W'(t);
    a.head = NODE_W'(h);
    a.cap = CAP_W'(c);
    a.price = IN_COST_W'(u);
    return a;
  endfunction

  initial begin
    arc_item_t g[$];
    bit [CFG_IDX_W-1:0] iq[$];
    bit [CFG_DATA_W-1:0] vq[$];
    int base, n, pct, rand_start;

    rst_n = 0;
    start = 0;
    in_tail_node = 0;
    in_head_node = 0;
    in_capacity = 0;
    in_unit_cost = 0;
    in_last_edge = 0;
    cfg_we = 0;
    cfg_index = 0;
    cfg_wdata = 0;
    idle_cycles = 0;
    arcs_sent = 0;
    graphs_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    wait_idle();

    // reset settings: 0 to 511, one unit, extreme capacity and cost
    send_graph('{mk(0, 511, 16'hffff, 15'h7fff)}, 0);

    // diamond graph, demand above the cut: infeasible
    g = '{mk(0, 1, 5, 1), mk(1, 3, 5, 1), mk(0, 2, 4, 5), mk(2, 3, 4, 5),
          mk(1, 2, 3, 0), mk(2, 1, 0, 9)};
    set_flow(0, 3, 16'hffff);
    send_graph(g, 0);
    // same graph, demand exactly at the cut
    set_flow(0, 3, 9);
    send_graph(g, 0);
    // path that needs a reverse arc to cancel flow
    set_flow(0, 3, 2);
    send_graph('{mk(0, 1, 1, 1), mk(1, 2, 1, 1), mk(2, 3, 1, 1), mk(0, 2, 1, 5),
                 mk(1, 3, 1, 5)}, 0);
    // zero demand
    set_flow(0, 3, 0);
    send_graph(g, 0);
    // source equals sink
    set_flow(3, 3, 5);
    send_graph(g, 0);
    // sink never reachable
    set_flow(0, 6, 1);
    send_graph('{mk(5, 6, 7, 2), mk(6, 0, 7, 2)}, 0);
    // highest node indexes and a zero-capacity arc
    set_flow(511, 510, 3);
    send_graph('{mk(511, 510, 0, 1), mk(511, 256, 2, 15'h4000), mk(256, 510, 9, 15'h3fff),
                 mk(511, 510, 1, 15'h7fff)}, 0);

    // random graphs in several idling phases
    rand_start = arcs_sent;
    while (arcs_sent - rand_start < RAND_ARCS) begin
      case (((arcs_sent - rand_start) * 4) / RAND_ARCS)
        0: pct = 0;
        1: pct = 82;
        2: pct = 0;
        default: pct = 9;
      endcase
      base = $urandom_range(NUM_NODES - 8);
      wait_idle();
      iq.delete();
      vq.delete();
      if ($urandom_range(3) != 0) begin
        iq.insert(iq.size(), CFG_SOURCE);
        vq.insert(vq.size(), CFG_DATA_W'((base + $urandom_range(7)) |
                                         ($urandom_range(127) << NODE_W)));
      end
      if ($urandom_range(3) != 0) begin
        iq.insert(iq.size(), CFG_SINK);
        vq.insert(vq.size(), ($urandom_range(15) == 0) ?
                             CFG_DATA_W'($urandom_range(16'hffff)) :
                             CFG_DATA_W'(base + $urandom_range(7)));
      end
      if ($urandom_range(2) != 0) begin
        iq.insert(iq.size(), CFG_DEMAND);
        case ($urandom_range(9))
          0: vq.insert(vq.size(), CFG_DATA_W'(0));
          1: vq.insert(vq.size(), CFG_DATA_W'($urandom_range(16'hffff)));
          default: vq.insert(vq.size(), CFG_DATA_W'($urandom_range(1, 30)));
        endcase
      end
      if ($urandom_range(15) == 0) begin
        iq.insert(iq.size(), CFG_SPARE);
        vq.insert(vq.size(), CFG_DATA_W'($urandom_range(16'hffff)));
      end
      write_regs(iq, vq);
      n = $urandom_range(1, 12);
      g.delete();
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(9) == 0)
          g.insert(g.size(), mk($urandom_range(NUM_NODES - 1), $urandom_range(NUM_NODES - 1),
                                $urandom_range(16'hffff), $urandom_range(15'h7fff)));
        else
          g.insert(g.size(), mk(base + $urandom_range(7), base + $urandom_range(7),
                                ($urandom_range(7) == 0) ? $urandom_range(16'hffff)
                                                         : $urandom_range(20),
                                ($urandom_range(7) == 0) ? $urandom_range(15'h7fff)
                                                         : $urandom_range(100)));
      end
      send_graph(g, pct);
    end

    // drain
    wait_idle();
    repeat (600) @(posedge clk);
    $display("covered %0d graphs from %0d arcs: hand-built corner cases, then random graphs",
             graphs_sent, arcs_sent);
    $display("%0d results checked, %0d mismatches", sb.results_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
